FILE: hdl/cts_pkg.sv
// shared constants, arctangent table and defaults for the cartesian to spherical core
// no dependencies
package cts_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int GUARD_BITS        = 8;
    localparam int HEAD_BITS         = 3;
    localparam int ANGLE_WIDTH       = 32;
    localparam int OUT_WIDTH         = 16;
    localparam int GAIN_WIDTH        = 20;
    localparam logic [GAIN_WIDTH-1:0]  GAIN_Q20    = 20'd636751;
    localparam logic [GAIN_WIDTH-1:0]  GAIN_ROUND  = 20'h80000;
    localparam logic [ANGLE_WIDTH-1:0] HALF_TURN   = 32'h8000_0000;
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_ROUND = 32'h0000_8000;
    localparam logic [OUT_WIDTH-1:0]   RADIUS_MAX  = 16'hFFFF;

    // atan(2^-i)/pi scaled by 2^31
    function automatic logic [ANGLE_WIDTH-1:0] atan_entry(input logic [4:0] idx);
        logic [ANGLE_WIDTH-1:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933405;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            5'd24:   val = 32'd41;
            5'd25:   val = 32'd20;
            5'd26:   val = 32'd10;
            5'd27:   val = 32'd5;
            5'd28:   val = 32'd3;
            5'd29:   val = 32'd1;
            5'd30:   val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

FILE: hdl/cts_point_if.sv
// request channel carrying one cartesian point
// depends on cts_pkg for the default coordinate width
interface cts_point_if #(
    parameter int COORD_WIDTH = cts_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface

FILE: hdl/cts_result_if.sv
// result channel carrying one spherical result
// depends on cts_pkg for the field width
interface cts_result_if;
    logic                                  valid;
    logic                                  ready;
    logic        [cts_pkg::OUT_WIDTH-1:0]  radius;
    logic        [cts_pkg::OUT_WIDTH-1:0]  polar_angle;
    logic signed [cts_pkg::OUT_WIDTH-1:0]  azimuth_angle;

    modport source (output valid, output radius, output polar_angle, output azimuth_angle,
                    input ready);
    modport sink   (input valid, input radius, input polar_angle, input azimuth_angle,
                    output ready);
endinterface

FILE: hdl/cts_vector_pass.sv
// pipelined cordic vectoring pass: angle of (a, b) and gain-compensated magnitude
// depends on cts_pkg
module cts_vector_pass #(
    parameter int IW     = cts_pkg::COORD_WIDTH_DEF + cts_pkg::GUARD_BITS + cts_pkg::HEAD_BITS,
    parameter int STAGES = cts_pkg::CORDIC_STAGES_DEF,
    parameter int TAG_W  = cts_pkg::OUT_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [IW-1:0]               in_a,
    input  logic signed [IW-1:0]               in_b,
    input  logic        [TAG_W-1:0]            in_tag,
    output logic                               out_valid,
    output logic        [IW-1:0]               out_mag,
    output logic        [cts_pkg::ANGLE_WIDTH-1:0] out_acc,
    output logic        [TAG_W-1:0]            out_tag
);
    import cts_pkg::*;

    localparam int MW = IW - 1;
    localparam int PW = MW + GAIN_WIDTH;

    logic [STAGES:0]              valid_reg;
    logic [STAGES:0]              zero_reg;
    logic [STAGES:0]              zero_next;
    logic signed [IW-1:0]         a_reg    [0:STAGES];
    logic signed [IW-1:0]         a_next   [0:STAGES];
    logic signed [IW-1:0]         b_reg    [0:STAGES];
    logic signed [IW-1:0]         b_next   [0:STAGES];
    logic [ANGLE_WIDTH-1:0]       acc_reg  [0:STAGES];
    logic [ANGLE_WIDTH-1:0]       acc_next [0:STAGES];
    logic [TAG_W-1:0]             tag_reg  [0:STAGES];
    logic [TAG_W-1:0]             tag_next [0:STAGES];

    logic                         mvalid_reg;
    logic [MW-1:0]                mag_reg;
    logic [MW-1:0]                mag_next;
    logic [ANGLE_WIDTH-1:0]       macc_reg;
    logic [TAG_W-1:0]             mtag_reg;
    logic [MW-1:0]                a_pos;
    logic [PW-1:0]                prod;

    always_comb
    begin
        // prep: fold left half plane into right, zero b passes straight through
        zero_next[0] = (in_b == '0);
        tag_next[0]  = in_tag;
        if (in_a[IW-1])
        begin
            a_next[0]   = -in_a;
            b_next[0]   = -in_b;
            acc_next[0] = HALF_TURN;
        end
        else
        begin
            a_next[0]   = in_a;
            b_next[0]   = in_b;
            acc_next[0] = '0;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            zero_next[i+1] = zero_reg[i];
            tag_next[i+1]  = tag_reg[i];
            if (zero_reg[i])
            begin
                a_next[i+1]   = a_reg[i];
                b_next[i+1]   = b_reg[i];
                acc_next[i+1] = acc_reg[i];
            end
            else if (!b_reg[i][IW-1])
            begin
                a_next[i+1]   = a_reg[i] + (b_reg[i] >>> i);
                b_next[i+1]   = b_reg[i] - (a_reg[i] >>> i);
                acc_next[i+1] = acc_reg[i] + atan_entry(5'(i));
            end
            else
            begin
                a_next[i+1]   = a_reg[i] - (b_reg[i] >>> i);
                b_next[i+1]   = b_reg[i] + (a_reg[i] >>> i);
                acc_next[i+1] = acc_reg[i] - atan_entry(5'(i));
            end
        end
    end

    // gain compensation
    always_comb
    begin
        a_pos = a_reg[STAGES][IW-1] ? '0 : a_reg[STAGES][MW-1:0];
        prod  = PW'(a_pos) * PW'(GAIN_Q20) + PW'(GAIN_ROUND);
        if (zero_reg[STAGES])
        begin
            mag_next = a_reg[STAGES][MW-1:0];
        end
        else
        begin
            mag_next = prod[PW-1:GAIN_WIDTH];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            mvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg  <= {valid_reg[STAGES-1:0], in_valid};
            mvalid_reg <= valid_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= zero_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            acc_reg  <= acc_next;
            tag_reg  <= tag_next;
            mag_reg  <= mag_next;
            macc_reg <= acc_reg[STAGES];
            mtag_reg <= tag_reg[STAGES];
        end
    end

    assign out_valid = mvalid_reg;
    assign out_mag   = {1'b0, mag_reg};
    assign out_acc   = macc_reg;
    assign out_tag   = mtag_reg;

endmodule

FILE: hdl/cartesian_to_spherical_core.sv
// Cartesian to spherical converter: one point per clock in, one (radius, theta, phi) out
// while no finished result waits. Two pipelined CORDIC vectoring passes; the first gives
// phi and sqrt(x^2+y^2), the second gives theta and the radius. Accepts a point every
// cycle unless a finished result waits; each pass has an input fold stage, the CORDIC
// stages and a gain multiply stage, followed by the output register. The pipeline moves
// as a whole and holds while a finished result waits.
// Angles are in units of pi/32768, phi wraps +pi to -32768, theta is 0 at the origin.
// Depends on cts_pkg, cts_point_if, cts_result_if and cts_vector_pass.
module cartesian_to_spherical_core #(
    parameter int COORD_WIDTH   = cts_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = cts_pkg::CORDIC_STAGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    cts_point_if.sink    point,
    cts_result_if.source result
);
    import cts_pkg::*;

    localparam int IW = COORD_WIDTH + GUARD_BITS + HEAD_BITS;
    localparam int RW = IW + 1 - GUARD_BITS + OUT_WIDTH;

    logic                       advance;
    logic signed [IW-1:0]       x_ext;
    logic signed [IW-1:0]       y_ext;
    logic signed [IW-1:0]       z_ext;

    logic                       p1_valid;
    logic [IW-1:0]              p1_mag;
    logic [ANGLE_WIDTH-1:0]     p1_acc;
    logic [IW-1:0]              p1_tag;
    logic [ANGLE_WIDTH-1:0]     phi_sum;

    logic                       p2_valid;
    logic [IW-1:0]              p2_mag;
    logic [ANGLE_WIDTH-1:0]     p2_acc;
    logic [OUT_WIDTH-1:0]       p2_tag;

    logic [IW:0]                rad_sum;
    logic [RW-1:0]              rad_wide;
    logic [ANGLE_WIDTH-1:0]     theta_clamp;
    logic [ANGLE_WIDTH:0]       theta_sum;

    logic                       out_valid_reg;
    logic [OUT_WIDTH-1:0]       radius_reg;
    logic [OUT_WIDTH-1:0]       radius_next;
    logic [OUT_WIDTH-1:0]       theta_reg;
    logic [OUT_WIDTH-1:0]       theta_next;
    logic [OUT_WIDTH-1:0]       phi_reg;

    assign advance     = !out_valid_reg || result.ready;
    assign point.ready = advance;

    assign x_ext = {{HEAD_BITS{point.x_coord[COORD_WIDTH-1]}}, point.x_coord, GUARD_BITS'(0)};
    assign y_ext = {{HEAD_BITS{point.y_coord[COORD_WIDTH-1]}}, point.y_coord, GUARD_BITS'(0)};
    assign z_ext = {{HEAD_BITS{point.z_coord[COORD_WIDTH-1]}}, point.z_coord, GUARD_BITS'(0)};

    cts_vector_pass #(
        .IW     (IW),
        .STAGES (CORDIC_STAGES),
        .TAG_W  (IW)
    ) u_pass_xy (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (point.valid),
        .in_a      (x_ext),
        .in_b      (y_ext),
        .in_tag    (z_ext),
        .out_valid (p1_valid),
        .out_mag   (p1_mag),
        .out_acc   (p1_acc),
        .out_tag   (p1_tag)
    );

    assign phi_sum = p1_acc + ANGLE_ROUND;

    cts_vector_pass #(
        .IW     (IW),
        .STAGES (CORDIC_STAGES),
        .TAG_W  (OUT_WIDTH)
    ) u_pass_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (p1_valid),
        .in_a      (p1_tag),
        .in_b      (p1_mag),
        .in_tag    (phi_sum[ANGLE_WIDTH-1:ANGLE_WIDTH-OUT_WIDTH]),
        .out_valid (p2_valid),
        .out_mag   (p2_mag),
        .out_acc   (p2_acc),
        .out_tag   (p2_tag)
    );

    always_comb
    begin
        rad_sum  = {1'b0, p2_mag} + (IW+1)'(1 << (GUARD_BITS - 1));
        rad_wide = RW'(rad_sum[IW:GUARD_BITS]);
        if (|rad_wide[RW-1:OUT_WIDTH])
        begin
            radius_next = RADIUS_MAX;
        end
        else
        begin
            radius_next = rad_wide[OUT_WIDTH-1:0];
        end

        // clamp theta to 0..pi
        if (p2_acc[ANGLE_WIDTH-1] && p2_acc[ANGLE_WIDTH-2])
        begin
            theta_clamp = '0;
        end
        else if (p2_acc > HALF_TURN)
        begin
            theta_clamp = HALF_TURN;
        end
        else
        begin
            theta_clamp = p2_acc;
        end
        theta_sum  = {1'b0, theta_clamp} + {1'b0, ANGLE_ROUND};
        theta_next = theta_sum[ANGLE_WIDTH-1:ANGLE_WIDTH-OUT_WIDTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= p2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && p2_valid)
        begin
            radius_reg <= radius_next;
            theta_reg  <= theta_next;
            phi_reg    <= p2_tag;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.radius        = radius_reg;
    assign result.polar_angle   = theta_reg;
    assign result.azimuth_angle = phi_reg;

endmodule

FILE: tb/tb.sv
// testbench for cartesian_to_spherical_core: directed points from a table, then random points
// results are checked against a cordic predictor written here; uses cts_pkg and both channel
// interfaces
`timescale 1ns / 1ps

module tb;

    import cts_pkg::*;

    localparam int STAGES     = CORDIC_STAGES_DEF;
    localparam int LATENCY    = 2 * (STAGES + 2) + 1;
    localparam int N_RANDOM   = 1878;
    localparam int HOLD_LEN   = 400;
    localparam logic signed [15:0] CMAX = 16'sh7FFF;
    localparam logic signed [15:0] CMIN = 16'sh8000;

    localparam logic [31:0] ATAN_Q31 [32] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087, 32'd667544,
        32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215,
        32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20, 32'd10,
        32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef struct packed {
        logic        [15:0] radius;
        logic        [15:0] polar_angle;
        logic signed [15:0] azimuth_angle;
    } sph_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               known;
        sph_t               want;
    } point_row_t;

    localparam sph_t NO_SPH = '{16'd0, 16'd0, 16'sd0};

    // typed expectations only for points on the z axis
    localparam int N_DIRECTED = 22;
    localparam point_row_t DIRECTED [N_DIRECTED] = '{
        '{16'sd0, 16'sd0, 16'sd0,  1'b1, '{16'd0, 16'd0, 16'sd0}},
        '{16'sd0, 16'sd0, CMAX,    1'b1, '{16'd32767, 16'd0, 16'sd0}},
        '{16'sd0, 16'sd0, CMIN,    1'b1, '{16'd32768, 16'd32768, 16'sd0}},
        '{16'sd0, 16'sd0, 16'sd1,  1'b1, '{16'd1, 16'd0, 16'sd0}},
        '{16'sd0, 16'sd0, -16'sd1, 1'b1, '{16'd1, 16'd32768, 16'sd0}},
        '{CMAX, 16'sd0, 16'sd0,    1'b0, NO_SPH},
        '{CMIN, 16'sd0, 16'sd0,    1'b0, NO_SPH},
        '{16'sd1, 16'sd0, 16'sd0,  1'b0, NO_SPH},
        '{-16'sd1, 16'sd0, 16'sd0, 1'b0, NO_SPH},
        '{16'sd0, CMAX, 16'sd0,    1'b0, NO_SPH},
        '{16'sd0, CMIN, 16'sd0,    1'b0, NO_SPH},
        '{CMAX, CMAX, CMAX,        1'b0, NO_SPH},
        '{CMIN, CMIN, CMIN,        1'b0, NO_SPH},
        '{CMIN, CMIN, CMAX,        1'b0, NO_SPH},
        '{CMAX, CMIN, CMIN,        1'b0, NO_SPH},
        '{CMIN, 16'sd1, 16'sd0,    1'b0, NO_SPH},
        '{CMIN, -16'sd1, 16'sd0,   1'b0, NO_SPH},
        '{16'sd1, 16'sd0, CMAX,    1'b0, NO_SPH},
        '{16'sd1, 16'sd0, CMIN,    1'b0, NO_SPH},
        '{16'sd1, 16'sd1, CMIN,    1'b0, NO_SPH},
        '{16'sd100, -16'sd100, 16'sd0, 1'b0, NO_SPH},
        '{-16'sd7, 16'sd3, 16'sd9, 1'b0, NO_SPH}
    };

    logic clk;
    logic rst_n;

    cts_point_if #(.COORD_WIDTH(COORD_WIDTH_DEF)) pt_if ();
    cts_result_if res_if ();

    cartesian_to_spherical_core #(
        .COORD_WIDTH   (COORD_WIDTH_DEF),
        .CORDIC_STAGES (STAGES)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (pt_if),
        .result (res_if)
    );

    sph_t spherical_q [$];
    int   mismatch_count = 0;
    int   send_gap_pct   = 26;
    int   recv_gap_pct   = 77;
    bit   hold_request   = 1'b0;

    // one vectoring pass: returns atan2(b, a) in units of pi/2^31, mag gets the scaled length
    function automatic logic [31:0] cordic_vector(input longint a_in, input longint b_in,
                                                  output longint mag);
        longint      a;
        longint      b;
        longint      a_sh;
        longint      b_sh;
        logic [31:0] acc;
        int          i;
        a   = a_in;
        b   = b_in;
        acc = '0;
        if (b == 0)
        begin
            mag = (a < 0) ? -a : a;
            return (a < 0) ? HALF_TURN : 32'd0;
        end
        if (a < 0)
        begin
            a   = -a;
            b   = -b;
            acc = HALF_TURN;
        end
        for (i = 0; i < STAGES; i++)
        begin
            a_sh = a >>> i;
            b_sh = b >>> i;
            if (b >= 0)
            begin
                a   = a + b_sh;
                b   = b - a_sh;
                acc = acc + ATAN_Q31[i];
            end
            else
            begin
                a   = a - b_sh;
                b   = b + a_sh;
                acc = acc - ATAN_Q31[i];
            end
        end
        if (a < 0)
            a = 0;
        mag = (a * longint'(GAIN_Q20) + longint'(GAIN_ROUND)) >>> GAIN_WIDTH;
        return acc;
    endfunction

    function automatic sph_t to_spherical(input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic signed [15:0] z);
        longint      rxy;
        longint      rho;
        longint      rad;
        longint      t;
        logic [31:0] phi_acc;
        logic [31:0] th_acc;
        logic [31:0] phi_sum;
        sph_t        s;
        phi_acc = cordic_vector(longint'(x) <<< GUARD_BITS, longint'(y) <<< GUARD_BITS, rxy);
        th_acc  = cordic_vector(longint'(z) <<< GUARD_BITS, rxy, rho);
        rad = (rho + (longint'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
        if (rad > longint'(RADIUS_MAX))
            rad = longint'(RADIUS_MAX);
        t = longint'(th_acc);
        if (th_acc >= 32'hC000_0000)
            t = t - (longint'(1) <<< 32);
        if (t < 0)
            t = 0;
        if (t > longint'(HALF_TURN))
            t = longint'(HALF_TURN);
        phi_sum         = phi_acc + ANGLE_ROUND;
        s.radius        = 16'(rad);
        s.polar_angle   = 16'((t + longint'(ANGLE_ROUND)) >>> 16);
        s.azimuth_angle = phi_sum[31:16];
        return s;
    endfunction

    function automatic logic signed [15:0] pick_coord(input int kind);
        logic signed [15:0] edge_vals [5];
        edge_vals = '{CMIN, -16'sd1, 16'sd0, 16'sd1, CMAX};
        case (kind)
            1:       return 16'($urandom_range(127)) - 16'sd64;
            2:       return edge_vals[$urandom_range(4)];
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic offer_point(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic signed [15:0] z, input sph_t want);
        while ($urandom_range(99) < send_gap_pct)
        begin
            pt_if.valid <= 1'b0;
            @(posedge clk);
        end
        pt_if.valid   <= 1'b1;
        pt_if.x_coord <= x;
        pt_if.y_coord <= y;
        pt_if.z_coord <= z;
        @(posedge clk);
        while (!pt_if.ready)
            @(posedge clk);
        spherical_q.push_back(want);
    endtask

    task automatic check_spherical();
        sph_t want;
        if (spherical_q.size() == 0)
        begin
            $error("result with no request pending: radius %0d polar %0d azimuth %0d",
                   res_if.radius, res_if.polar_angle, res_if.azimuth_angle);
            mismatch_count++;
            return;
        end
        want = spherical_q.pop_front();
        if (res_if.radius !== want.radius)
        begin
            $error("radius: expected %0d, actual %0d", want.radius, res_if.radius);
            mismatch_count++;
        end
        if (res_if.polar_angle !== want.polar_angle)
        begin
            $error("polar_angle: expected %0d, actual %0d", want.polar_angle,
                   res_if.polar_angle);
            mismatch_count++;
        end
        if (res_if.azimuth_angle !== want.azimuth_angle)
        begin
            $error("azimuth_angle: expected %0d, actual %0d", want.azimuth_angle,
                   res_if.azimuth_angle);
            mismatch_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    // result side: random stalls, plus one long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
                check_spherical();
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_LEN;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // request side
    initial
    begin
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        int                 kind;
        int                 n;
        pt_if.valid   <= 1'b0;
        pt_if.x_coord <= '0;
        pt_if.y_coord <= '0;
        pt_if.z_coord <= '0;
        @(posedge rst_n);
        @(posedge clk);

        for (n = 0; n < N_DIRECTED; n++)
            offer_point(DIRECTED[n].x, DIRECTED[n].y, DIRECTED[n].z,
                        DIRECTED[n].known ? DIRECTED[n].want
                                          : to_spherical(DIRECTED[n].x, DIRECTED[n].y,
                                                         DIRECTED[n].z));

        for (n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 3)
            begin
                send_gap_pct = 77;
                recv_gap_pct = 26;
            end
            else if (n == 2 * N_RANDOM / 3)
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
                hold_request = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                x = pick_coord(0);
                y = pick_coord(0);
                z = pick_coord(0);
            end
            else if (kind < 60)
            begin
                x = pick_coord(1);
                y = pick_coord(1);
                z = pick_coord(1);
            end
            else if (kind < 75)
            begin
                // one of x, y zero
                x = pick_coord(0);
                y = pick_coord(0);
                z = pick_coord($urandom_range(1));
                if ($urandom_range(1))
                    y = '0;
                else
                    x = '0;
            end
            else if (kind < 85)
            begin
                x = '0;
                y = '0;
                z = pick_coord($urandom_range(2));
            end
            else
            begin
                x = pick_coord(2);
                y = pick_coord(2);
                z = pick_coord(2);
            end
            offer_point(x, y, z, to_spherical(x, y, z));
        end
        pt_if.valid <= 1'b0;

        while (spherical_q.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: files.f
hdl/cts_pkg.sv
hdl/cts_point_if.sv
hdl/cts_result_if.sv
hdl/cts_vector_pass.sv
hdl/cartesian_to_spherical_core.sv
tb/tb.sv
